FILE: rtl/mte_pkg.sv
// Shared types and constants for the MIDI track event encoder.
// No dependencies; imported by every module of the block.
package mte_pkg;

    // Default number of delta-time bytes (variable-length quantity)
    localparam int MAX_DELTA_BYTES_DEF = 4;

    // Descriptor queue between classifier and byte sequencer
    localparam int QUEUE_DEPTH = 2;

    // Channel voice commands; code 7 is undefined and sends only the delta time
    typedef enum logic [2:0] {
        CMD_NOTE_OFF       = 3'd0,
        CMD_NOTE_ON        = 3'd1,
        CMD_POLYTOUCH      = 3'd2,
        CMD_CONTROL_CHANGE = 3'd3,
        CMD_PROGRAM_CHANGE = 3'd4,
        CMD_AFTERTOUCH     = 3'd5,
        CMD_PITCHWHEEL     = 3'd6
    } cmd_t;

    // Data byte counts
    localparam logic [1:0] NDATA_NONE = 2'd0;
    localparam logic [1:0] NDATA_ONE  = 2'd1;
    localparam logic [1:0] NDATA_TWO  = 2'd2;

    // Everything after the delta time, as decided by the front end
    typedef struct packed {
        logic       has_status;
        logic [7:0] status;
        logic [1:0] ndata;
        logic [6:0] d1;
        logic [6:0] d2;
    } mte_ctl_t;

endpackage

FILE: rtl/mte_front.sv
// Front end: clamps the delta time, splits it into 7-bit groups and decides
// status/data bytes under running status. Depends on mte_pkg.
module mte_front
    import mte_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF,
    localparam int DW = 7 * MAX_DELTA_BYTES,
    localparam int GW = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [2:0]           cmd,
    input  logic                 track_start,
    input  logic signed [28:0]   delta_time,
    input  logic [3:0]           channel,
    input  logic [6:0]           data1,
    input  logic [6:0]           data2,
    input  logic signed [13:0]   bend,
    output mte_ctl_t             ctl,
    output logic [DW-1:0]        groups,
    output logic [GW-1:0]        top_grp
);

    logic [7:0]  running_status_reg, running_status_next;
    logic        status_valid_reg, status_valid_next;
    logic [27:0] mag;
    logic [DW-1:0] dval;
    logic        eff_valid;
    logic [7:0]  status;
    logic [13:0] bend_ofs;

    assign mag = delta_time[28] ? 28'd0 : delta_time[27:0];

    // saturate to what fits in the configured byte count
    generate
        if (DW > 28) begin : g_wide
            assign dval = {{(DW-28){1'b0}}, mag};
        end else if (DW == 28) begin : g_exact
            assign dval = mag;
        end else begin : g_sat
            assign dval = (|mag[27:DW]) ? {DW{1'b1}} : mag[DW-1:0];
        end
    endgenerate

    assign groups = dval;

    always_comb
    begin
        top_grp = '0;
        for (int g = 1; g < MAX_DELTA_BYTES; g++)
        begin
            if (dval[7*g +: 7] != 7'd0)
                top_grp = GW'(g);
        end
    end

    // 0x80 | cmd << 4 | channel
    assign status    = {1'b1, cmd, channel};
    assign eff_valid = status_valid_reg && !track_start;
    // +8192 on a 14-bit two's complement value flips the sign bit
    assign bend_ofs  = {~bend[13], bend[12:0]};

    always_comb
    begin
        ctl.status     = status;
        ctl.has_status = !(eff_valid && (status == running_status_reg));
        ctl.ndata      = NDATA_TWO;
        ctl.d1         = data1;
        ctl.d2         = data2;
        unique case (cmd)
            CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLYTOUCH, CMD_CONTROL_CHANGE:
            begin
                ctl.ndata = NDATA_TWO;
            end
            CMD_PROGRAM_CHANGE, CMD_AFTERTOUCH:
            begin
                ctl.ndata = NDATA_ONE;
            end
            CMD_PITCHWHEEL:
            begin
                ctl.ndata = NDATA_TWO;
                ctl.d1    = bend_ofs[6:0];
                ctl.d2    = bend_ofs[13:7];
            end
            default:
            begin
                ctl.ndata      = NDATA_NONE;
                ctl.has_status = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        running_status_next = running_status_reg;
        status_valid_next   = status_valid_reg;
        if (accept)
        begin
            status_valid_next = eff_valid;
            if (ctl.ndata != NDATA_NONE)
            begin
                running_status_next = status;
                status_valid_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= 8'd0;
            status_valid_reg   <= 1'b0;
        end
        else
        begin
            running_status_reg <= running_status_next;
            status_valid_reg   <= status_valid_next;
        end
    end

endmodule

FILE: rtl/mte_queue.sv
// Small flip-flop FIFO carrying event descriptors from front to back end.
// Depends on mte_pkg.
module mte_queue
    import mte_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/mte_back.sv
// Back end: walks one descriptor byte by byte (delta groups, status, data)
// into the output register. Depends on mte_pkg.
module mte_back
    import mte_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF,
    localparam int DW = 7 * MAX_DELTA_BYTES,
    localparam int GW = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  mte_ctl_t      q_ctl,
    input  logic [DW-1:0] q_groups,
    input  logic [GW-1:0] q_top,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    byte_out,
    output logic          last
);

    typedef enum logic [1:0] {
        PH_DELTA,
        PH_STATUS,
        PH_D1,
        PH_D2
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic          cur_valid_reg, cur_valid_next;
    mte_ctl_t      cur_ctl_reg, cur_ctl_next;
    logic [DW-1:0] cur_groups_reg, cur_groups_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;

    logic [6:0]    grp_byte;
    logic          adv;
    logic          last_b;

    assign empty    = !out_valid_reg;
    assign byte_out = byte_reg;
    assign last     = last_reg;

    always_comb
    begin
        grp_byte = 7'd0;
        for (int g = 0; g < MAX_DELTA_BYTES; g++)
        begin
            if (grp_reg == GW'(g))
                grp_byte = cur_groups_reg[7*g +: 7];
        end
    end

    assign adv = cur_valid_reg && (!out_valid_reg || pop);

    always_comb
    begin
        phase_next      = phase_reg;
        cur_valid_next  = cur_valid_reg;
        cur_ctl_next    = cur_ctl_reg;
        cur_groups_next = cur_groups_reg;
        grp_next        = grp_reg;
        out_valid_next  = out_valid_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        last_b          = 1'b0;

        if (out_valid_reg && pop)
            out_valid_next = 1'b0;

        if (adv)
        begin
            unique case (phase_reg)
                PH_DELTA:
                begin
                    // continuation bit on every delta byte but the lowest
                    byte_next = {grp_reg != '0, grp_byte};
                    last_b    = (grp_reg == '0) && (cur_ctl_reg.ndata == NDATA_NONE);
                    if (grp_reg != '0)
                        grp_next = grp_reg - 1'b1;
                    else if (cur_ctl_reg.has_status)
                        phase_next = PH_STATUS;
                    else
                        phase_next = PH_D1;
                end
                PH_STATUS:
                begin
                    byte_next  = cur_ctl_reg.status;
                    phase_next = PH_D1;
                end
                PH_D1:
                begin
                    byte_next  = {1'b0, cur_ctl_reg.d1};
                    last_b     = (cur_ctl_reg.ndata == NDATA_ONE);
                    phase_next = PH_D2;
                end
                PH_D2:
                begin
                    byte_next = {1'b0, cur_ctl_reg.d2};
                    last_b    = 1'b1;
                end
                default:
                begin
                    last_b = 1'b1;
                end
            endcase
            out_valid_next = 1'b1;
            last_next      = last_b;
            if (last_b)
                cur_valid_next = 1'b0;
        end

        q_pop = (!cur_valid_reg || (adv && last_b)) && !q_empty;
        if (q_pop)
        begin
            cur_valid_next  = 1'b1;
            cur_ctl_next    = q_ctl;
            cur_groups_next = q_groups;
            grp_next        = q_top;
            phase_next      = PH_DELTA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DELTA;
            cur_valid_reg  <= 1'b0;
            cur_ctl_reg    <= '0;
            cur_groups_reg <= '0;
            grp_reg        <= '0;
            out_valid_reg  <= 1'b0;
            byte_reg       <= 8'd0;
            last_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cur_valid_reg  <= cur_valid_next;
            cur_ctl_reg    <= cur_ctl_next;
            cur_groups_reg <= cur_groups_next;
            grp_reg        <= grp_next;
            out_valid_reg  <= out_valid_next;
            byte_reg       <= byte_next;
            last_reg       <= last_next;
        end
    end

endmodule

FILE: rtl/midi_track_event_encoder_top.sv
// MIDI track event encoder: one channel voice event in, its SMF track bytes out.
// First byte path on an idle block: queue entry, current descriptor, output register.
// Throughput: one output byte per cycle while pop drains the output register; an event
// is 1 to 3+MAX_DELTA_BYTES bytes (delta bytes + optional status + 0 to 2 data bytes).
// Input beats are taken every cycle until the 2-entry descriptor queue fills.
// Reset (rst_n, async): queue and output empty, running status cleared.
module midi_track_event_encoder_top
    import mte_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF,
    localparam int DW = 7 * MAX_DELTA_BYTES,
    localparam int GW = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1,
    localparam int QW = $bits(mte_ctl_t) + DW + GW
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         cmd,
    input  logic               track_start,
    input  logic signed [28:0] delta_time,
    input  logic [3:0]         channel,
    input  logic [6:0]         data1,
    input  logic [6:0]         data2,
    input  logic signed [13:0] bend,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         byte_out,
    output logic               last
);

    logic          accept;
    mte_ctl_t      f_ctl, q_ctl;
    logic [DW-1:0] f_groups, q_groups;
    logic [GW-1:0] f_top, q_top;
    logic [QW-1:0] q_rdata;
    logic          q_empty, q_pop;

    assign accept = push && !full;

    mte_front #(
        .MAX_DELTA_BYTES (MAX_DELTA_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .track_start (track_start),
        .delta_time  (delta_time),
        .channel     (channel),
        .data1       (data1),
        .data2       (data2),
        .bend        (bend),
        .ctl         (f_ctl),
        .groups      (f_groups),
        .top_grp     (f_top)
    );

    mte_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({f_ctl, f_groups, f_top}),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    assign {q_ctl, q_groups, q_top} = q_rdata;

    mte_back #(
        .MAX_DELTA_BYTES (MAX_DELTA_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_ctl    (q_ctl),
        .q_groups (q_groups),
        .q_top    (q_top),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .byte_out (byte_out),
        .last     (last)
    );

endmodule
